### rtl/lpd_pkg.sv
// Package for the length-prefix deframer: widths, reset constants and the
// result record passed between the parser and the output stage. No dependencies.
package lpd_pkg;

  localparam int DATA_W = 8;
  localparam int CFG_W  = 32;

  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 32'd1048576;

  // One result as it travels from the parser into the output buffer
  typedef struct packed {
    logic [DATA_W-1:0] payload_byte;
    logic              last_of_frame;
    logic              empty_frame;
    logic              stream_error;
  } lpd_result_t;

endpackage

### rtl/lpd_stream_if.sv
// Byte stream channel of the deframer: valid/ready plus one received byte.
// Depends on lpd_pkg for the data width.
interface lpd_stream_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/lpd_result_if.sv
// Result channel of the deframer: valid/ready plus the per-result fields.
// Depends on lpd_pkg for the data width.
interface lpd_result_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] payload_byte;
  logic              last_of_frame;
  logic              empty_frame;
  logic              stream_error;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output empty_frame, output stream_error, input ready);
  modport sink   (input valid, input payload_byte, input last_of_frame,
                  input empty_frame, input stream_error, output ready);
endinterface

### rtl/lpd_cfg_if.sv
// Configuration write channel: valid/ready plus the maximum frame length.
// Depends on lpd_pkg for the register width.
interface lpd_cfg_if import lpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lpd_parser.sv
// Frame parser: gathers the length prefix, checks it, counts the payload and
// forms one result per transaction where one is due. Depends on lpd_pkg and the
// stream and configuration interfaces.
module lpd_parser import lpd_pkg::*; #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst,
  lpd_stream_if.sink   stream,
  lpd_cfg_if.sink      cfg,
  input  logic         can_accept,
  output logic         push_valid,
  output lpd_result_t  push_res
);

  localparam int LEN_W = 8 * PREFIX_BYTES;
  localparam int CNT_W = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PREFIX_BYTES - 1);

  logic [CFG_W-1:0] max_frame_bytes;
  logic             in_body, in_body_next;
  logic [CNT_W-1:0] prefix_count, prefix_count_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic             error_latched, error_latched_next;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] remaining_dec;
  logic             accept;

  // Accept whenever the output buffer has room; configuration is always taken
  assign stream.ready = can_accept;
  assign cfg.ready    = 1'b1;
  assign accept       = stream.valid && can_accept;

  // Hold the configured limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg.valid) begin
      max_frame_bytes <= cfg.data;
    end
  end

  // Gather the leading prefix bytes; the final byte completes the length directly
  generate
    if (PREFIX_BYTES > 1) begin : g_gather
      localparam int GATHER_W = 8 * (PREFIX_BYTES - 1);
      logic [GATHER_W-1:0] length_gather;

      always_ff @(posedge clk) begin
        if (accept && !error_latched && !in_body && prefix_count != LAST_CNT) begin
          length_gather[{prefix_count, 3'b000} +: 8] <= stream.data_byte;
        end
      end

      assign frame_len = {stream.data_byte, length_gather};
    end else begin : g_single
      assign frame_len = stream.data_byte;
    end
  endgenerate

  assign remaining_dec = bytes_remaining - LEN_W'(1);

  // Next state and result for the current transaction
  always_comb begin
    in_body_next         = in_body;
    prefix_count_next    = prefix_count;
    bytes_remaining_next = bytes_remaining;
    error_latched_next   = error_latched;
    push_valid           = 1'b0;
    push_res             = '0;

    if (accept && !error_latched) begin
      if (in_body) begin
        // Forward a payload byte and close the frame on its last one
        bytes_remaining_next  = remaining_dec;
        push_valid            = 1'b1;
        push_res.payload_byte = stream.data_byte;
        if (remaining_dec == '0) begin
          in_body_next           = 1'b0;
          push_res.last_of_frame = 1'b1;
        end
      end else if (prefix_count != LAST_CNT) begin
        prefix_count_next = prefix_count + CNT_W'(1);
      end else begin
        // Prefix complete: check it against the limit
        prefix_count_next = '0;
        if (CFG_W'(frame_len) > max_frame_bytes) begin
          error_latched_next    = 1'b1;
          push_valid            = 1'b1;
          push_res.stream_error = 1'b1;
        end else if (frame_len == '0) begin
          push_valid             = 1'b1;
          push_res.last_of_frame = 1'b1;
          push_res.empty_frame   = 1'b1;
        end else begin
          in_body_next         = 1'b1;
          bytes_remaining_next = frame_len;
        end
      end
    end
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body         <= 1'b0;
      prefix_count    <= '0;
      bytes_remaining <= '0;
      error_latched   <= 1'b0;
    end else begin
      in_body         <= in_body_next;
      prefix_count    <= prefix_count_next;
      bytes_remaining <= bytes_remaining_next;
      error_latched   <= error_latched_next;
    end
  end

  // Error is sticky until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("stream error cleared without reset");

  // A frame body always has bytes left to send
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_body |-> bytes_remaining != '0)
    else $error("in frame body with no bytes remaining");

  // The error can only be raised from prefix parsing, so the body is never open
  a_error_no_body: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !in_body)
    else $error("frame body open after stream error");

  // Prefix counter stays within the prefix length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    prefix_count <= LAST_CNT)
    else $error("prefix counter out of range");

endmodule

### rtl/lpd_out_stage.sv
// Output buffer: a result register backed by a skid register, so the parser
// keeps taking bytes while a result waits. Depends on lpd_pkg and lpd_result_if.
module lpd_out_stage import lpd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  lpd_result_t   push_res,
  output logic          can_accept,
  lpd_result_if.source  result
);

  logic        main_valid;
  logic        skid_valid;
  lpd_result_t main_res;
  lpd_result_t skid_res;
  logic        pop;

  assign pop        = main_valid && result.ready;
  assign can_accept = !skid_valid;

  // Control: refill from skid first, else take the new result
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push_valid) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push_valid) begin
      if (main_valid && !pop) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end
  end

  assign result.valid         = main_valid;
  assign result.payload_byte  = main_res.payload_byte;
  assign result.last_of_frame = main_res.last_of_frame;
  assign result.empty_frame   = main_res.empty_frame;
  assign result.stream_error  = main_res.stream_error;

  // The skid register only fills behind a full result register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid register holds a result ahead of the output");

  // No result is pushed while the buffer is full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !skid_valid)
    else $error("result pushed into full output buffer");

  // A waiting skid entry moves forward when the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result.ready |=> main_valid && !skid_valid)
    else $error("skid entry not moved forward");

endmodule

### rtl/length_prefix_deframer.sv
// Length-prefix deframer, top level: a byte parser and a two-entry output
// buffer. Depends on lpd_pkg, the three channel interfaces and the two submodules.
//
// Takes a framed byte stream at one byte per clock cycle while the output
// buffer has room: each frame is a PREFIX_BYTES-byte little-endian length
// (first byte least significant) followed by that many payload bytes. Every
// payload byte gives one result, the final one marked last_of_frame; a zero
// length gives a single result marked empty and last on the final prefix
// byte. A length above max_frame_bytes gives one result with stream_error
// set, after which all input is accepted and dropped until reset. Results
// are registered in the output buffer. The per-byte work is one length
// compare and a counter decrement; the stream keeps moving at one byte per
// cycle while the result consumer accepts one result per cycle, and the
// two-entry output buffer takes one more result after the consumer stalls
// before the stream is held. Configuration writes are always accepted; a new
// limit applies to the next completed prefix.
module length_prefix_deframer import lpd_pkg::*; #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst,
  lpd_stream_if.sink   stream,
  lpd_cfg_if.sink      cfg,
  lpd_result_if.source result
);

  logic        can_accept;
  logic        push_valid;
  lpd_result_t push_res;

  lpd_parser #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .cfg        (cfg),
    .can_accept (can_accept),
    .push_valid (push_valid),
    .push_res   (push_res)
  );

  lpd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_res   (push_res),
    .can_accept (can_accept),
    .result     (result)
  );

endmodule
